>>> sv/regex_infix_to_postfix_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the regex infix to postfix block
// Each macro expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef REGEX_INFIX_TO_POSTFIX_TOP_DEFINES_SVH
`define REGEX_INFIX_TO_POSTFIX_TOP_DEFINES_SVH

// same-cycle implication
`define RXP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RXP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rxp_pkg.sv
// ---------------------------------------------------------------------------
// rxp_pkg
// Types, character codes and helpers shared by the regex to postfix block.
// ---------------------------------------------------------------------------
package rxp_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic [7:0] sym_out;
    logic       sym_valid;
    logic       end_of_run;
    logic       expr_done;
    logic [2:0] err_code;
  } out_t;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CAT    = 8'h26;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_Z      = 8'h7A;

  // stack entry codes, ordered by precedence
  localparam logic [1:0] OPC_LPAREN = 2'd0;
  localparam logic [1:0] OPC_ALT    = 2'd1;
  localparam logic [1:0] OPC_CAT    = 2'd2;
  localparam logic [1:0] OPC_STAR   = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW = 3'd1;
  localparam logic [2:0] ERR_UNM_CLOSE = 3'd2;
  localparam logic [2:0] ERR_UNM_OPEN = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd4;

  // character classes
  localparam logic [2:0] CL_LETTER = 3'd0;
  localparam logic [2:0] CL_LPAREN = 3'd1;
  localparam logic [2:0] CL_RPAREN = 3'd2;
  localparam logic [2:0] CL_STAR   = 3'd3;
  localparam logic [2:0] CL_BAR    = 3'd4;
  localparam logic [2:0] CL_BAD    = 3'd5;

  function automatic logic [2:0] char_class(input logic [7:0] ch);
    logic [2:0] c;
    if (ch inside {[CH_A:CH_Z]}) c = CL_LETTER;
    else if (ch == CH_LPAREN)    c = CL_LPAREN;
    else if (ch == CH_RPAREN)    c = CL_RPAREN;
    else if (ch == CH_STAR)      c = CL_STAR;
    else if (ch == CH_BAR)       c = CL_BAR;
    else                         c = CL_BAD;
    return c;
  endfunction

  function automatic logic [7:0] op_char(input logic [1:0] code);
    logic [7:0] c;
    case (code)
      OPC_LPAREN: c = CH_LPAREN;
      OPC_ALT:    c = CH_BAR;
      OPC_CAT:    c = CH_CAT;
      default:    c = CH_STAR;
    endcase
    return c;
  endfunction

endpackage

>>> sv/rxp_stack_mem.sv
// ---------------------------------------------------------------------------
// rxp_stack_mem
// Operator stack storage: one write port, one registered read port.
// ---------------------------------------------------------------------------
module rxp_stack_mem #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/rxp_out_stage.sv
// ---------------------------------------------------------------------------
// rxp_out_stage
// Result output register; decouples the sequencer from out_stall.
// ---------------------------------------------------------------------------
module rxp_out_stage
  import rxp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  out_t push_beat,
  output logic ready,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  assign ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ready) begin
      out_valid_nxt = push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      out_data_r <= push_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/rxp_seq.sv
// ---------------------------------------------------------------------------
// rxp_seq
// Shunting-yard sequencer: walks the operator stack through the memory,
// one entry per read/modify pass, and holds one result back so the last
// beat of each item can be tagged.
// ---------------------------------------------------------------------------
module rxp_seq
  import rxp_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH),
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_t           in_data,
  output logic          oq_push,
  output out_t          oq_beat,
  input  logic          oq_ready,
  output logic          mem_wr_en,
  output logic [AW-1:0] mem_wr_addr,
  output logic [1:0]    mem_wr_data,
  output logic          mem_rd_en,
  output logic [AW-1:0] mem_rd_addr,
  input  logic [1:0]    mem_rd_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACT  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_OP   = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;

  localparam logic [1:0] PH_CONCAT = 2'd0;
  localparam logic [1:0] PH_MAIN   = 2'd1;
  localparam logic [1:0] PH_FLUSH  = 2'd2;

  localparam logic [1:0] LP_APPLY = 2'd0;
  localparam logic [1:0] LP_CLOSE = 2'd1;
  localparam logic [1:0] LP_FLUSH = 2'd2;

  localparam logic [LW-1:0] LVL_FULL = LW'(DEPTH);

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [1:0]    loop_r, loop_nxt;
  logic [1:0]    code_r, code_nxt;
  logic [2:0]    cls_r, cls_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic          fin_r, fin_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic          prev_r, prev_nxt;
  logic          any_r, any_nxt;
  logic          pend_v_r, pend_v_nxt;
  out_t          pend_r, pend_nxt;

  // per-cycle intent, applied only when any emit can proceed
  logic          i_emit, i_pop, i_push, i_adv, i_go;
  logic [1:0]    i_pcode;
  out_t          i_beat;
  logic [2:0]    i_state;
  logic          can_emit, lvl_nz, lvl_full;
  logic [LW-1:0] lvl_m1;
  logic [2:0]    in_cls;

  assign in_stall = (state_r != S_IDLE);
  assign lvl_nz   = (level_r != '0);
  assign lvl_full = (level_r >= LVL_FULL);
  assign lvl_m1   = level_r - 1'b1;
  assign can_emit = !pend_v_r || oq_ready;
  assign in_cls   = char_class(in_data.char_in);

  assign mem_rd_en   = (state_r == S_RD);
  assign mem_rd_addr = lvl_m1[AW-1:0];
  assign mem_wr_addr = level_r[AW-1:0];
  assign mem_wr_data = i_pcode;

  function automatic out_t mk_beat(input logic [7:0] s, input logic v, input logic [2:0] e);
    out_t b;
    b.sym_out    = s;
    b.sym_valid  = v;
    b.end_of_run = 1'b0;
    b.expr_done  = 1'b0;
    b.err_code   = e;
    return b;
  endfunction

  always_comb begin
    i_emit  = 1'b0;
    i_pop   = 1'b0;
    i_push  = 1'b0;
    i_adv   = 1'b0;
    i_pcode = code_r;
    i_beat  = mk_beat(8'h00, 1'b0, ERR_NONE);
    i_state = state_r;
    loop_nxt = loop_r;
    code_nxt = code_r;

    case (state_r)
      S_ACT: begin
        case (phase_r)
          PH_CONCAT: begin
            loop_nxt = LP_APPLY;
            code_nxt = OPC_CAT;
            i_state  = S_RD;
          end
          PH_FLUSH: begin
            loop_nxt = LP_FLUSH;
            i_state  = S_RD;
          end
          default: begin
            case (cls_r)
              CL_LETTER: begin
                i_emit = 1'b1;
                i_beat = mk_beat(ch_r, 1'b1, ERR_NONE);
                i_adv  = 1'b1;
              end
              CL_LPAREN: begin
                i_push  = 1'b1;
                i_pcode = OPC_LPAREN;
                i_adv   = 1'b1;
              end
              CL_RPAREN: begin
                loop_nxt = LP_CLOSE;
                i_state  = S_RD;
              end
              CL_STAR: begin
                loop_nxt = LP_APPLY;
                code_nxt = OPC_STAR;
                i_state  = S_RD;
              end
              CL_BAR: begin
                loop_nxt = LP_APPLY;
                code_nxt = OPC_ALT;
                i_state  = S_RD;
              end
              default: begin
                i_emit = 1'b1;
                i_beat = mk_beat(8'h00, 1'b0, ERR_BAD_CHAR);
                i_adv  = 1'b1;
              end
            endcase
          end
        endcase
      end
      S_RD: begin
        i_state = S_OP;
      end
      S_OP: begin
        case (loop_r)
          LP_APPLY: begin
            if (lvl_nz && (mem_rd_data >= code_r)) begin
              i_emit  = 1'b1;
              i_beat  = mk_beat(op_char(mem_rd_data), 1'b1, ERR_NONE);
              i_pop   = 1'b1;
              i_state = S_RD;
            end else begin
              i_push  = 1'b1;
              i_pcode = code_r;
              i_adv   = 1'b1;
            end
          end
          LP_CLOSE: begin
            if (lvl_nz && (mem_rd_data != OPC_LPAREN)) begin
              i_emit  = 1'b1;
              i_beat  = mk_beat(op_char(mem_rd_data), 1'b1, ERR_NONE);
              i_pop   = 1'b1;
              i_state = S_RD;
            end else if (!lvl_nz) begin
              i_emit = 1'b1;
              i_beat = mk_beat(8'h00, 1'b0, ERR_UNM_CLOSE);
              i_adv  = 1'b1;
            end else begin
              // matching open paren is dropped
              i_pop = 1'b1;
              i_adv = 1'b1;
            end
          end
          default: begin
            if (lvl_nz) begin
              i_emit  = 1'b1;
              i_beat  = (mem_rd_data == OPC_LPAREN) ?
                        mk_beat(8'h00, 1'b0, ERR_UNM_OPEN) :
                        mk_beat(op_char(mem_rd_data), 1'b1, ERR_NONE);
              i_pop   = 1'b1;
              i_state = S_RD;
            end else begin
              i_adv = 1'b1;
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    // a push onto a full stack becomes an overflow error
    if (i_push && lvl_full) begin
      i_emit = 1'b1;
      i_beat = mk_beat(8'h00, 1'b0, ERR_OVERFLOW);
    end
    i_go = !i_emit || can_emit;
  end

  assign mem_wr_en = i_go && i_push && !lvl_full;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    cls_nxt    = cls_r;
    ch_nxt     = ch_r;
    fin_nxt    = fin_r;
    level_nxt  = level_r;
    prev_nxt   = prev_r;
    any_nxt    = any_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    oq_push    = 1'b0;
    oq_beat    = pend_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ch_nxt    = in_data.char_in;
          fin_nxt   = in_data.is_final;
          cls_nxt   = in_cls;
          any_nxt   = 1'b0;
          phase_nxt = (prev_r && (in_cls == CL_LETTER || in_cls == CL_LPAREN)) ?
                      PH_CONCAT : PH_MAIN;
          state_nxt = S_ACT;
        end
      end
      S_END: begin
        if (fin_r && !any_r) begin
          // empty final: lone marker beat
          if (oq_ready) begin
            oq_push            = 1'b1;
            oq_beat            = mk_beat(8'h00, 1'b0, ERR_NONE);
            oq_beat.end_of_run = 1'b1;
            oq_beat.expr_done  = 1'b1;
            level_nxt          = '0;
            prev_nxt           = 1'b0;
            state_nxt          = S_IDLE;
          end
        end else if (pend_v_r) begin
          if (oq_ready) begin
            oq_push            = 1'b1;
            oq_beat.end_of_run = 1'b1;
            oq_beat.expr_done  = fin_r;
            pend_v_nxt         = 1'b0;
            if (fin_r) begin
              level_nxt = '0;
              prev_nxt  = 1'b0;
            end
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        if (i_go) begin
          state_nxt = i_state;
          if (i_emit) begin
            oq_push    = pend_v_r;
            pend_nxt   = i_beat;
            pend_v_nxt = 1'b1;
            any_nxt    = 1'b1;
          end
          if (i_pop) begin
            level_nxt = lvl_m1;
          end else if (i_push && !lvl_full) begin
            level_nxt = level_r + 1'b1;
          end
          if (i_adv) begin
            case (phase_r)
              PH_CONCAT: begin
                phase_nxt = PH_MAIN;
                state_nxt = S_ACT;
              end
              PH_MAIN: begin
                prev_nxt  = (cls_r == CL_LETTER) || (cls_r == CL_STAR) ||
                            (cls_r == CL_RPAREN);
                phase_nxt = PH_FLUSH;
                state_nxt = fin_r ? S_ACT : S_END;
              end
              default: begin
                state_nxt = S_END;
              end
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      level_r  <= '0;
      prev_r   <= 1'b0;
      pend_v_r <= 1'b0;
      any_r    <= 1'b0;
      phase_r  <= PH_MAIN;
      loop_r   <= LP_APPLY;
    end else begin
      state_r  <= state_nxt;
      level_r  <= level_nxt;
      prev_r   <= prev_nxt;
      pend_v_r <= pend_v_nxt;
      any_r    <= any_nxt;
      phase_r  <= phase_nxt;
      loop_r   <= loop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    cls_r  <= cls_nxt;
    ch_r   <= ch_nxt;
    fin_r  <= fin_nxt;
    pend_r <= pend_nxt;
  end

endmodule

>>> sv/regex_infix_to_postfix_top.sv
// Each output beat waits in a hold-back register until the next is formed or the item ends,
//   then passes to the output register; a new input beat is taken only while idle.
// Each stack probe reads the stack memory through its registered read port (S_RD), then
//   updates (S_OP); there is one probe per pop plus the one that ends the search; an
//   implicit concat and a final flush each add a pass, and out_stall can hold the flow.
// Reset (rst_n low, synchronous) clears level, flags, sequencer and output register.
// ---------------------------------------------------------------------------
// regex_infix_to_postfix_top
// Regex infix to postfix converter with implicit concatenation insertion.
// ---------------------------------------------------------------------------
module regex_infix_to_postfix_top
  import rxp_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic          oq_push, oq_ready;
  out_t          oq_beat;
  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [1:0]    mem_wr_data, mem_rd_data;

  rxp_seq #(.DEPTH(STACK_DEPTH)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .oq_push    (oq_push),
    .oq_beat    (oq_beat),
    .oq_ready   (oq_ready),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  rxp_stack_mem #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  rxp_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (oq_push),
    .push_beat(oq_beat),
    .ready    (oq_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

>>> sv/rxp_checker.sv
// ---------------------------------------------------------------------------
// rxp_checker
// Port-level checks for the regex to postfix block, bound to the top level.
// ---------------------------------------------------------------------------
`include "regex_infix_to_postfix_top_defines.svh"

module rxp_checker
  import rxp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `RXP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "out beat dropped under stall")
  `RXP_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data), "out beat changed under stall")
  `RXP_ASSERT_NXT(a_in_busy, in_valid && !in_stall, in_stall, "new beat taken before item finished")
  `RXP_ASSERT_IMP(a_err_nosym, out_valid && (out_data.err_code != ERR_NONE), !out_data.sym_valid, "error beat carries a symbol")
  `RXP_ASSERT_IMP(a_done_end, out_valid && out_data.expr_done, out_data.end_of_run, "expr_done without end_of_run")

endmodule

bind regex_infix_to_postfix_top rxp_checker u_rxp_checker (.*);
